// File: rtl/ift_pkg.sv
`timescale 1ns / 1ps

package ift_pkg;

	localparam int LEN_LIMIT = 255;
	localparam logic [7:0] LEN_CAP = (LEN_LIMIT > 255) ? 8'd255 : 8'(LEN_LIMIT);

	localparam logic [1:0] PH_START    = 2'd0;
	localparam logic [1:0] PH_FIELD    = 2'd1;
	localparam logic [1:0] PH_DELIM    = 2'd2;
	localparam logic [1:0] PH_AFTER_CR = 2'd3;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UC_D  = 8'h44;
	localparam logic [7:0] CH_UC_E  = 8'h45;
	localparam logic [7:0] CH_LC_D  = 8'h64;
	localparam logic [7:0] CH_LC_E  = 8'h65;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_input;
		logic       string_mode;
	} ift_in_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_out;
		logic       token_end;
		logic [7:0] token_length;
		logic       is_float;
	} ift_out_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       in_quote;
		logic       seen_ampersand;
		logic       float_seen;
		logic [7:0] field_length;
		logic       latched_string_mode;
	} ift_state_t;

endpackage

// File: rtl/input_field_tokenizer.sv
`timescale 1ns / 1ps

// Character field tokenizer that takes one character request per clock cycle and
// gives at most one result per character: the request is held in an input
// register, and the field decision is made in combinational logic into the result
// register. A character that only skips a blank or a delimiter gives no result. The
// sustained rate of one request per cycle is set by that combinational decision
// step, and holds as long as results are taken; the input stalls only while the
// result register is full and not being taken. The max_token_len register is
// written through its own channel, whose ready is always high, and must only be
// written while no request is in flight.
module input_field_tokenizer import ift_pkg::*; #(
	parameter int TOKEN_LEN_LIMIT = LEN_LIMIT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ift_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output ift_out_t   out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic       valid_s1;
	ift_in_t    item_s1;
	ift_state_t state_q;
	ift_state_t state_nxt;
	logic [7:0] max_len_q;
	logic       room;
	logic       step;
	logic       res_valid;
	ift_out_t   res;

	assign cfg_ready = 1'b1;
	assign step = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_START, default: '0};
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

	ift_step #(
		.TOKEN_LEN_LIMIT (TOKEN_LEN_LIMIT)
	) u_step (
		.st            (state_q),
		.item          (item_s1),
		.max_token_len (max_len_q),
		.nxt           (state_nxt),
		.res_valid     (res_valid),
		.res           (res)
	);

	ift_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res_valid (res_valid),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("Input stalled without a blocked result.");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid) |=> out_valid)
		else $error("A result was lost between step and result register.");

	a_no_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.char_valid || out_data.token_end))
		else $error("A result carries neither a character nor a field end.");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.token_end) |->
		(out_data.token_length == 8'd0 && !out_data.is_float))
		else $error("Length or float flag set on a result that does not end a field.");

endmodule

// File: rtl/ift_step.sv
`timescale 1ns / 1ps

module ift_step import ift_pkg::*; #(
	parameter int TOKEN_LEN_LIMIT = LEN_LIMIT
) (
	input  ift_state_t st,
	input  ift_in_t    item,
	input  logic [7:0] max_token_len,
	output ift_state_t nxt,
	output logic       res_valid,
	output ift_out_t   res
);

	localparam logic [7:0] LIMIT_CAP = (TOKEN_LEN_LIMIT > 255) ? 8'd255 : 8'(TOKEN_LEN_LIMIT);

	logic [7:0] limit;
	logic [7:0] c;
	logic [7:0] ch;
	logic       blank;
	logic       field_start;
	logic       go_field;
	logic       eoi_eff;
	logic       do_save;
	logic       do_end;
	ift_state_t b;

	always_comb begin
		limit = (max_token_len == 8'd0) ? 8'd1 : max_token_len;
		if (limit > LIMIT_CAP) begin
			limit = LIMIT_CAP;
		end
	end

	always_comb begin
		c = item.char_in;
		ch = c;
		blank = (c inside {CH_SPACE, CH_TAB});
		field_start = 1'b0;
		go_field = 1'b0;
		eoi_eff = item.end_of_input;
		do_save = 1'b0;
		do_end = 1'b0;
		b = st;

		case (st.phase)
			PH_FIELD: begin
				go_field = 1'b1;
			end
			PH_DELIM: begin
				if (item.end_of_input || c == CH_COMMA || c == CH_LF) begin
					b.phase = PH_START;
				end else if (blank) begin
					b.phase = PH_DELIM;
				end else if (c == CH_CR) begin
					b.phase = PH_AFTER_CR;
				end else begin
					field_start = 1'b1;
					eoi_eff = 1'b0;
				end
			end
			PH_AFTER_CR: begin
				if (item.end_of_input || c == CH_LF) begin
					b.phase = PH_START;
				end else begin
					field_start = 1'b1;
					eoi_eff = 1'b0;
				end
			end
			default: begin
				field_start = 1'b1;
			end
		endcase

		if (field_start) begin
			b.phase = PH_START;
			b.in_quote = 1'b0;
			b.seen_ampersand = 1'b0;
			b.float_seen = 1'b0;
			b.field_length = 8'd0;
			b.latched_string_mode = item.string_mode;
			if (eoi_eff) begin
				do_end = 1'b1;
			end else if (!blank) begin
				b.phase = PH_FIELD;
				go_field = 1'b1;
			end
		end

		nxt = b;

		if (go_field) begin
			if (eoi_eff) begin
				nxt.phase = PH_START;
				do_end = 1'b1;
			end else begin
				case (c)
					CH_LF: begin
						nxt.phase = PH_START;
						do_end = 1'b1;
					end
					CH_CR: begin
						nxt.phase = PH_AFTER_CR;
						do_end = 1'b1;
					end
					CH_QUOTE: begin
						if (!b.in_quote) begin
							if (b.field_length == 8'd0) begin
								nxt.in_quote = 1'b1;
							end else begin
								do_save = 1'b1;
							end
						end else begin
							nxt.in_quote = 1'b0;
							if (b.latched_string_mode) begin
								nxt.phase = PH_DELIM;
								do_end = 1'b1;
							end
						end
					end
					CH_COMMA: begin
						if (!b.in_quote) begin
							nxt.phase = PH_START;
							do_end = 1'b1;
						end else begin
							do_save = 1'b1;
						end
					end
					CH_AMP: begin
						nxt.seen_ampersand = 1'b1;
						do_save = 1'b1;
					end
					CH_LC_D, CH_UC_D: begin
						if (!b.seen_ampersand) begin
							nxt.float_seen = 1'b1;
							if (!b.latched_string_mode) begin
								ch = c + 8'd1;
							end
						end
						do_save = 1'b1;
					end
					CH_LC_E, CH_UC_E, CH_DOT: begin
						if (!b.seen_ampersand) begin
							nxt.float_seen = 1'b1;
						end
						do_save = 1'b1;
					end
					CH_TAB, CH_SPACE: begin
						if (!b.in_quote && !b.latched_string_mode) begin
							nxt.phase = PH_DELIM;
							do_end = 1'b1;
						end else begin
							do_save = 1'b1;
						end
					end
					default: begin
						do_save = 1'b1;
					end
				endcase
			end
		end

		if (do_save) begin
			nxt.field_length = b.field_length + 8'd1;
			if (nxt.field_length >= limit) begin
				nxt.phase = PH_DELIM;
				do_end = 1'b1;
			end
		end

		res_valid = do_save || do_end;
		res.char_valid = do_save;
		res.char_out = do_save ? ch : 8'd0;
		res.token_end = do_end;
		res.token_length = do_end ? nxt.field_length : 8'd0;
		res.is_float = do_end ? nxt.float_seen : 1'b0;
	end

endmodule

// File: rtl/ift_out_reg.sv
`timescale 1ns / 1ps

module ift_out_reg import ift_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  logic     res_valid,
	input  ift_out_t res,
	output logic     room,
	output logic     out_valid,
	input  logic     out_ready,
	output ift_out_t out_data
);

	logic     out_valid_q;
	ift_out_t out_data_q;

	assign room = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_data_q <= res;
		end
	end

endmodule
